// ===== rtl/core/fcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the frame checker
// Header layout, status codes, result beat format and the CRC32C byte update.
// ----------------------------------------------------------------------------
package fcc_pkg;

	localparam int HDR_BYTES  = 14;
	localparam int OFS_TYPE   = 4;
	localparam int OFS_FLAGS  = 5;
	localparam int OFS_LEN    = 6;
	localparam int OFS_CRC    = 10;
	localparam int CNT_W      = 34;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int LVL_W      = 3;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_SHORT  = 3'd1,
		ST_MAGIC  = 3'd2,
		ST_LENGTH = 3'd3,
		ST_CRC    = 3'd4
	} status_t;

	typedef struct packed {
		logic        is_verdict;
		logic [7:0]  payload_byte;
		logic [7:0]  message_type;
		logic [7:0]  message_flags;
		logic [31:0] payload_length;
		status_t     status;
		logic        run_last;
	} result_t;

	// up to two result beats produced by one byte, first beat in a
	typedef struct packed {
		logic [1:0] n;
		result_t    a;
		result_t    b;
	} push_t;

	typedef struct packed {
		logic             room2;
		logic [LVL_W-1:0] level;
	} fifo_stat_t;

	// reflected castagnoli update, one byte
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'b0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/fcc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_if: channel interfaces of the frame checker
// Byte input, result output and magic word write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface fcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, data_byte, frame_last, input ready);
	modport sink   (input valid, data_byte, frame_last, output ready);
endinterface

interface fcc_result_if;
	logic        valid;
	logic        ready;
	logic        is_verdict;
	logic [7:0]  payload_byte;
	logic [7:0]  message_type;
	logic [7:0]  message_flags;
	logic [31:0] payload_length;
	logic [2:0]  status;
	logic        run_last;

	modport source (output valid, is_verdict, payload_byte, message_type, message_flags,
		payload_length, status, run_last, input ready);
	modport sink   (input valid, is_verdict, payload_byte, message_type, message_flags,
		payload_length, status, run_last, output ready);
endinterface

interface fcc_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] magic_word;

	modport source (output valid, magic_word, input ready);
	modport sink   (input valid, magic_word, output ready);
endinterface

// ===== rtl/core/frame_checker_crc32c.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker_crc32c: length-prefixed frame checker with CRC32C
// Passes payload bytes through and issues a verdict on the final byte.
//
//   channel  dir  beat contents
//   frame    in   data_byte, frame_last
//   result   out  is_verdict, payload_byte, message_type, message_flags,
//                 payload_length, status, run_last
//   cfg      in   magic_word
//
// one byte accepted per cycle; its result beats reach the queue from the input register
// a final payload byte gives two beats, the verdict leaving the queue after the payload
// the input register stalls while the four-entry result queue has fewer than two free
// reset clears count, crc and queue at once; header bytes are not reset
// cfg beats are taken in any cycle
// ----------------------------------------------------------------------------
module frame_checker_crc32c (
	input  logic         clk,
	input  logic         arst_n,
	fcc_byte_if.sink     frame,
	fcc_result_if.source result,
	fcc_cfg_if.sink      cfg
);
	import fcc_pkg::*;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       in_last_s1;
	logic [31:0] magic_q;
	logic       drain;
	logic       fire;
	push_t      push;
	fifo_stat_t fifo_stat;

	assign drain       = fifo_stat.room2;
	assign fire        = in_valid_s1 && drain;
	assign frame.ready = !in_valid_s1 || drain;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			magic_q     <= '0;
		end else begin
			if (frame.valid && frame.ready) begin
				in_valid_s1 <= 1'b1;
			end else if (fire) begin
				in_valid_s1 <= 1'b0;
			end
			if (cfg.valid) begin
				magic_q <= cfg.magic_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			in_byte_s1 <= frame.data_byte;
			in_last_s1 <= frame.frame_last;
		end
	end

	fcc_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_byte  (in_byte_s1),
		.frame_last (in_last_s1),
		.magic      (magic_q),
		.push       (push)
	);

	fcc_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.result (result),
		.stat   (fifo_stat)
	);

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready) |=> in_valid_s1)
		else $error("accepted beat not held in input register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !drain) |=>
		(in_valid_s1 && $stable(in_byte_s1) && $stable(in_last_s1)))
		else $error("stalled input register lost its beat");

	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.is_verdict) |-> result.run_last)
		else $error("verdict beat without run_last");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_stat.level <= LVL_W'(FIFO_DEPTH)) && (!fire || drain))
		else $error("result queue overrun");

endmodule

// ===== rtl/core/fcc_frame.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_frame: per-byte frame tracking
// Header capture, byte count, running CRC32C and the verdict of each frame.
// ----------------------------------------------------------------------------
module fcc_frame (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     data_byte,
	input  logic           frame_last,
	input  logic [31:0]    magic,
	output fcc_pkg::push_t push
);
	import fcc_pkg::*;

	logic [7:0]       hdr_q [HDR_BYTES];
	logic [CNT_W-1:0] count_q;
	logic [31:0]      crc_q;

	logic             in_hdr;
	logic [CNT_W-1:0] count_inc;
	logic [31:0]      crc_new;
	logic [7:0]       hdr13;
	logic [31:0]      magic_rx;
	logic [31:0]      len_rx;
	logic [31:0]      crc_rx;
	status_t          st;
	result_t          pay_r;
	result_t          ver_r;

	assign in_hdr    = count_q < CNT_W'(HDR_BYTES);
	assign count_inc = (count_q == {CNT_W{1'b1}}) ? count_q : count_q + CNT_W'(1);
	assign crc_new   = in_hdr ? crc_q : crc32c_byte(crc_q, data_byte);

	// last header byte may arrive with the final flag
	assign hdr13    = (count_q == CNT_W'(HDR_BYTES - 1)) ? data_byte : hdr_q[HDR_BYTES-1];
	assign magic_rx = {hdr_q[3], hdr_q[2], hdr_q[1], hdr_q[0]};
	assign len_rx   = {hdr_q[OFS_LEN+3], hdr_q[OFS_LEN+2], hdr_q[OFS_LEN+1], hdr_q[OFS_LEN]};
	assign crc_rx   = {hdr13, hdr_q[OFS_CRC+2], hdr_q[OFS_CRC+1], hdr_q[OFS_CRC]};

	always_comb begin
		if (count_inc < CNT_W'(HDR_BYTES)) begin
			st = ST_SHORT;
		end else if (magic_rx != magic) begin
			st = ST_MAGIC;
		end else if (count_inc != CNT_W'(HDR_BYTES) + {2'b0, len_rx}) begin
			st = ST_LENGTH;
		end else if (~crc_new != crc_rx) begin
			st = ST_CRC;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		pay_r              = '0;
		pay_r.payload_byte = data_byte;
		pay_r.run_last     = !frame_last;

		ver_r            = '0;
		ver_r.is_verdict = 1'b1;
		ver_r.status     = st;
		ver_r.run_last   = 1'b1;
		if (st != ST_SHORT) begin
			ver_r.message_type   = hdr_q[OFS_TYPE];
			ver_r.message_flags  = hdr_q[OFS_FLAGS];
			ver_r.payload_length = len_rx;
		end

		push = '0;
		if (fire) begin
			if (!in_hdr) begin
				push.a = pay_r;
				push.b = ver_r;
				push.n = frame_last ? 2'd2 : 2'd1;
			end else if (frame_last) begin
				push.a = ver_r;
				push.n = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= CRC_INIT;
		end else if (fire) begin
			if (frame_last) begin
				count_q <= '0;
				crc_q   <= CRC_INIT;
			end else begin
				count_q <= count_inc;
				crc_q   <= crc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && in_hdr) begin
			hdr_q[count_q[3:0]] <= data_byte;
		end
	end

endmodule

// ===== rtl/core/fcc_result_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcc_result_fifo: result queue
// Four-entry queue taking up to two result beats a cycle, one out when ready.
// ----------------------------------------------------------------------------
module fcc_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  fcc_pkg::push_t      push,
	fcc_result_if.source        result,
	output fcc_pkg::fifo_stat_t stat
);
	import fcc_pkg::*;

	result_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;
	result_t          head;

	assign head = mem_q[rd_ptr_q];
	assign pop  = result.valid && result.ready;

	assign result.valid          = level_q != '0;
	assign result.is_verdict     = head.is_verdict;
	assign result.payload_byte   = head.payload_byte;
	assign result.message_type   = head.message_type;
	assign result.message_flags  = head.message_flags;
	assign result.payload_length = head.payload_length;
	assign result.status         = head.status;
	assign result.run_last       = head.run_last;

	assign stat.room2 = level_q <= LVL_W'(FIFO_DEPTH - 2);
	assign stat.level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			level_q  <= level_q + LVL_W'(push.n) - LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + PTR_W'(1)] <= push.b;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for frame_checker_crc32c
// Streams framed messages through the byte channel with random gaps and
// back-pressure. A local frame model folds each accepted beat into its own
// header copy, byte count and CRC32C, then queues the payload and verdict
// beats. Every result beat is compared against the oldest queued one.
// ----------------------------------------------------------------------------
module tb;
	import fcc_pkg::*;

	typedef struct {
		logic       hold;
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	typedef enum int {
		FK_GOOD,
		FK_BAD_MAGIC,
		FK_BAD_LENGTH,
		FK_BAD_CRC,
		FK_SHORT,
		FK_NOISE
	} frame_kind_t;

	localparam int               HOLD_CYCLES  = 300;
	localparam int               DRAIN_CYCLES = 12;
	localparam logic [CNT_W-1:0] COUNT_TOP    = '1;

	logic clk = 1'b0;
	logic arst_n;

	fcc_byte_if   frame_ch ();
	fcc_result_if result_ch ();
	fcc_cfg_if    cfg_ch ();

	frame_checker_crc32c uut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	wire_byte_t tx_bytes [$];
	wire_byte_t tx_next;
	logic [7:0] frame_buf [$];
	result_t    beats_due [$];
	result_t    beat_seen;
	result_t    beat_want;

	// frame model state
	logic [7:0]       hdr_copy [HDR_BYTES];
	logic [CNT_W-1:0] rx_count  = '0;
	logic [31:0]      crc_run   = CRC_INIT;
	logic [31:0]      magic_now = '0;

	int   send_idle_pct  = 32;
	int   recv_idle_pct  = 75;
	logic long_hold_arm  = 1'b0;
	logic long_hold_done = 1'b0;
	int   hold_left      = 0;
	int   mismatches     = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] hdr_word(input int at);
		return {hdr_copy[at + 3], hdr_copy[at + 2], hdr_copy[at + 1], hdr_copy[at]};
	endfunction

	function automatic void absorb_byte(input logic [7:0] b, input logic last);
		result_t     r;
		logic [31:0] plen;
		if (rx_count < CNT_W'(HDR_BYTES)) begin
			hdr_copy[rx_count[3:0]] = b;
		end else begin
			crc_run = crc_fold(crc_run, b);
			r = '0;
			r.payload_byte = b;
			r.run_last = !last;
			beats_due = {beats_due, r};
		end
		if (rx_count != COUNT_TOP) begin
			rx_count = rx_count + 1'b1;
		end
		if (last) begin
			r = '0;
			r.is_verdict = 1'b1;
			r.run_last = 1'b1;
			if (rx_count < CNT_W'(HDR_BYTES)) begin
				r.status = ST_SHORT;
			end else begin
				plen = hdr_word(OFS_LEN);
				r.message_type = hdr_copy[OFS_TYPE];
				r.message_flags = hdr_copy[OFS_FLAGS];
				r.payload_length = plen;
				if (hdr_word(0) != magic_now) begin
					r.status = ST_MAGIC;
				end else if (rx_count != CNT_W'(HDR_BYTES) + CNT_W'(plen)) begin
					r.status = ST_LENGTH;
				end else if (~crc_run != hdr_word(OFS_CRC)) begin
					r.status = ST_CRC;
				end else begin
					r.status = ST_OK;
				end
			end
			beats_due = {beats_due, r};
			rx_count = '0;
			crc_run = CRC_INIT;
		end
	endfunction

	function automatic int flush_frame();
		int n;
		n = frame_buf.size();
		for (int i = 0; i < n; i++) begin
			tx_bytes = {tx_bytes,
				wire_byte_t'{hold: 1'b0, data: frame_buf[i], last: (i == n - 1)}};
		end
		frame_buf.delete();
		return n;
	endfunction

	function automatic int queue_frame(input frame_kind_t kind);
		logic [7:0]  body [$];
		logic [31:0] plen;
		logic [31:0] crc;
		logic [31:0] magic;
		logic [7:0]  mtype;
		logic [7:0]  mflags;
		int          n;
		frame_buf.delete();
		if (kind == FK_SHORT || kind == FK_NOISE) begin
			n = (kind == FK_SHORT) ? $urandom_range(13, 1) : $urandom_range(40, 1);
			for (int i = 0; i < n; i++) begin
				frame_buf = {frame_buf, 8'($urandom)};
			end
			return flush_frame();
		end
		n = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(16);
		crc = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			body = {body, 8'($urandom)};
			crc = crc_fold(crc, body[i]);
		end
		crc = ~crc;
		plen = 32'(n);
		magic = magic_now;
		mtype = 8'($urandom);
		mflags = 8'($urandom);
		case (kind)
			FK_BAD_MAGIC: begin
				magic = magic ^ (32'd1 << $urandom_range(31));
			end
			FK_BAD_LENGTH: begin
				case ($urandom_range(2))
					0: plen = plen + 1;
					1: plen = plen - 1;
					default: plen = $urandom;
				endcase
			end
			FK_BAD_CRC: begin
				crc = crc ^ (32'd1 << $urandom_range(31));
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) begin
			frame_buf = {frame_buf, magic[8 * i +: 8]};
		end
		frame_buf = {frame_buf, mtype};
		frame_buf = {frame_buf, mflags};
		for (int i = 0; i < 4; i++) begin
			frame_buf = {frame_buf, plen[8 * i +: 8]};
		end
		for (int i = 0; i < 4; i++) begin
			frame_buf = {frame_buf, crc[8 * i +: 8]};
		end
		foreach (body[i]) begin
			frame_buf = {frame_buf, body[i]};
		end
		return flush_frame();
	endfunction

	function automatic void flag_beat(input string what, input result_t want, input result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected %p, got %p", $time, what, want, got);
		end
	endfunction

	task automatic fill_frames(input int count);
		int          sent;
		int          pick;
		frame_kind_t kind;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			kind = (pick < 60) ? FK_GOOD :
				(pick < 68) ? FK_BAD_MAGIC :
				(pick < 76) ? FK_BAD_LENGTH :
				(pick < 84) ? FK_BAD_CRC :
				(pick < 92) ? FK_SHORT : FK_NOISE;
			sent += queue_frame(kind);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (tx_bytes.size() != 0 || beats_due.size() != 0 || frame_ch.valid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_magic(input logic [31:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.magic_word <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		magic_now = value;
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
			frame_ch.data_byte <= '0;
			frame_ch.frame_last <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				absorb_byte(frame_ch.data_byte, frame_ch.frame_last);
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (tx_bytes.size() != 0 && tx_bytes[0].hold) begin
					// hold off until every result is back
					if (beats_due.size() == 0) begin
						void'(tx_bytes.pop_front());
					end
					frame_ch.valid <= 1'b0;
				end else if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					tx_next = tx_bytes.pop_front();
					frame_ch.valid <= 1'b1;
					frame_ch.data_byte <= tx_next.data;
					frame_ch.frame_last <= tx_next.last;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				beat_seen.is_verdict = result_ch.is_verdict;
				beat_seen.payload_byte = result_ch.payload_byte;
				beat_seen.message_type = result_ch.message_type;
				beat_seen.message_flags = result_ch.message_flags;
				beat_seen.payload_length = result_ch.payload_length;
				beat_seen.status = status_t'(result_ch.status);
				beat_seen.run_last = result_ch.run_last;
				if (beats_due.size() == 0) begin
					flag_beat("unexpected beat", '0, beat_seen);
				end else begin
					beat_want = beats_due.pop_front();
					if (beat_seen !== beat_want) begin
						flag_beat("beat mismatch", beat_want, beat_seen);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_ch.ready <= 1'b0;
			end else if (long_hold_arm && !long_hold_done) begin
				// long stall so the result queue fills and the input backs up
				hold_left <= HOLD_CYCLES;
				long_hold_done <= 1'b1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.magic_word = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames against the reset magic of zero
		@(negedge clk);
		frame_buf = {8'hFF};
		void'(flush_frame());
		frame_buf = {8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
			8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		void'(flush_frame());
		frame_buf = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
		void'(flush_frame());
		wait_drained();

		write_magic(32'hFFFF_FFFF);
		@(negedge clk);
		fill_frames(640);
		wait_drained();

		send_idle_pct = 75;
		recv_idle_pct = 32;
		write_magic($urandom);
		@(negedge clk);
		fill_frames(320);
		tx_bytes = {tx_bytes, wire_byte_t'{hold: 1'b1, data: 8'h00, last: 1'b0}};
		fill_frames(320);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_magic('0);
		@(negedge clk);
		long_hold_arm = 1'b1;
		fill_frames(650);
		wait_drained();

		if (mismatches == 0 && beats_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== frame_checker_crc32c.f =====
rtl/core/fcc_pkg.sv
rtl/core/fcc_if.sv
rtl/core/fcc_frame.sv
rtl/core/fcc_result_fifo.sv
rtl/core/frame_checker_crc32c.sv
tb/sv/tb.sv
